@@ rtl/irprop_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// irprop_pkg
// Shared types and constants for the iRPROP- weight update engine.
// ----------------------------------------------------------------------------
package irprop_pkg;

  localparam int unsigned ENTRIES_DEFAULT = 1024;

  localparam int unsigned INDEX_W  = 10;
  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned STEP_W   = 31;
  localparam int unsigned FRAC_W   = 24;
  localparam int unsigned PADDR_W  = 5;
  localparam int unsigned PDATA_W  = 32;

  localparam logic [STEP_W-1:0] STEP_INITIAL_RST  = 31'd1677722;
  localparam logic [STEP_W-1:0] STEP_MAX_RST      = 31'd838860800;
  localparam logic [STEP_W-1:0] STEP_MIN_RST      = 31'd17;
  localparam logic [STEP_W-1:0] GROW_FACTOR_RST   = 31'd20132659;
  localparam logic [STEP_W-1:0] SHRINK_FACTOR_RST = 31'd8388608;

  localparam logic [STEP_W-1:0] STEP_SAT = {STEP_W{1'b1}};

  typedef enum logic {
    OP_LOAD   = 1'b0,
    OP_UPDATE = 1'b1
  } op_t;

  typedef enum logic [2:0] {
    REG_STEP_INITIAL  = 3'd0,
    REG_STEP_MAX      = 3'd1,
    REG_STEP_MIN      = 3'd2,
    REG_GROW_FACTOR   = 3'd3,
    REG_SHRINK_FACTOR = 3'd4
  } reg_index_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] weight;
    logic        [STEP_W-1:0]  step;
    logic signed [VALUE_W-1:0] last_grad;
  } entry_t;

endpackage

@@ rtl/irprop_minus_weight_update.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// irprop_minus_weight_update
// iRPROP- update engine: per-entry weight, step and last gradient held in
// one synchronous memory, updated by read-modify-write.
//
//   channel  handshake            payload
//   in       in_valid / in_ready  operation, entry_index, value
//   out      out_valid/out_ready  entry_index_res, new_weight, new_step,
//                                 sign_flipped
//   cfg      psel/penable/pready  paddr, pwrite, pwdata, prdata
//
// an item passes capture, index wrap and memory read, step multiply and
// write-back into the output register in turn; the single memory port and
// the multiplier set that sequence.
// one item is in flight at a time, so repeated indices need no forwarding.
// a held output register stalls write-back until the transaction is taken.
// reset clears control and config registers; the memory is not cleared.
// ----------------------------------------------------------------------------
module irprop_minus_weight_update
  import irprop_pkg::*;
#(
  parameter int unsigned ENTRIES = ENTRIES_DEFAULT
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic                      operation,
  input  logic [INDEX_W-1:0]        entry_index,
  input  logic signed [VALUE_W-1:0] value,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [INDEX_W-1:0]        entry_index_res,
  output logic signed [VALUE_W-1:0] new_weight,
  output logic [STEP_W-1:0]         new_step,
  output logic                      sign_flipped,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [PADDR_W-1:0]        paddr,
  input  logic [PDATA_W-1:0]        pwdata,
  output logic [PDATA_W-1:0]        prdata,
  output logic                      pready
);

  localparam int unsigned IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned WRAP_SH = 2 * INDEX_W;
  localparam int unsigned WRAP_W = WRAP_SH + INDEX_W;
  localparam int unsigned WRAP_RECIP = (ENTRIES >= (1 << INDEX_W)) ? 1
                                     : ((1 << WRAP_SH) + ENTRIES - 1) / ENTRIES;
  localparam logic [INDEX_W-1:0] ENTRIES_IDX = INDEX_W'(ENTRIES);
  localparam int unsigned PROD_W = 2 * STEP_W;
  localparam int unsigned SH_W = PROD_W - FRAC_W;

  typedef enum logic [1:0] {
    S_IDLE,
    S_ADDR,
    S_READ,
    S_WRITE
  } state_t;

  typedef enum logic [1:0] {
    P_PLAIN,
    P_SAME,
    P_FLIP
  } path_t;

  state_t state;

  logic [STEP_W-1:0] step_initial;
  logic [STEP_W-1:0] step_max;
  logic [STEP_W-1:0] step_min;
  logic [STEP_W-1:0] grow_factor;
  logic [STEP_W-1:0] shrink_factor;

  entry_t mem [ENTRIES];
  entry_t rd_data;

  logic                      op;
  logic [INDEX_W-1:0]        raw_index;
  logic signed [VALUE_W-1:0] val;
  logic [INDEX_W-1:0]        idx;
  logic [INDEX_W-1:0]        idx_next;

  path_t                     path;
  logic [PROD_W-1:0]         prod;
  logic signed [VALUE_W-1:0] old_weight;
  logic [STEP_W-1:0]         old_step;

  // configuration port
  logic cfg_write;
  assign pready = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      step_initial  <= STEP_INITIAL_RST;
      step_max      <= STEP_MAX_RST;
      step_min      <= STEP_MIN_RST;
      grow_factor   <= GROW_FACTOR_RST;
      shrink_factor <= SHRINK_FACTOR_RST;
    end else if (cfg_write) begin
      case (paddr[PADDR_W-1:2])
        REG_STEP_INITIAL:  step_initial  <= pwdata[STEP_W-1:0];
        REG_STEP_MAX:      step_max      <= pwdata[STEP_W-1:0];
        REG_STEP_MIN:      step_min      <= pwdata[STEP_W-1:0];
        REG_GROW_FACTOR:   grow_factor   <= pwdata[STEP_W-1:0];
        REG_SHRINK_FACTOR: shrink_factor <= pwdata[STEP_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[PADDR_W-1:2])
      REG_STEP_INITIAL:  prdata = {1'b0, step_initial};
      REG_STEP_MAX:      prdata = {1'b0, step_max};
      REG_STEP_MIN:      prdata = {1'b0, step_min};
      REG_GROW_FACTOR:   prdata = {1'b0, grow_factor};
      REG_SHRINK_FACTOR: prdata = {1'b0, shrink_factor};
      default:           prdata = '0;
    endcase
  end

  // index wrap by reciprocal multiplication, exact over the index range
  logic [WRAP_W-1:0]  wrap_prod;
  logic [INDEX_W-1:0] wrap_quot;
  assign wrap_prod = WRAP_W'(raw_index) * WRAP_W'(WRAP_RECIP);
  assign wrap_quot = wrap_prod[WRAP_W-1:WRAP_SH];
  assign idx_next  = (ENTRIES >= (1 << INDEX_W)) ? raw_index
                   : raw_index - INDEX_W'(wrap_quot * ENTRIES_IDX);

  // sign test on read data
  logic g_pos, g_neg, l_pos, l_neg;
  logic same_sign, flip_sign;
  assign g_neg = val[VALUE_W-1];
  assign g_pos = !val[VALUE_W-1] && (val != '0);
  assign l_neg = rd_data.last_grad[VALUE_W-1];
  assign l_pos = !rd_data.last_grad[VALUE_W-1] && (rd_data.last_grad != '0);
  assign same_sign = (g_pos && l_pos) || (g_neg && l_neg);
  assign flip_sign = (g_pos && l_neg) || (g_neg && l_pos);

  // step and weight after the multiply
  logic [SH_W-1:0]           prod_sh;
  logic [STEP_W-1:0]         grown;
  logic [STEP_W-1:0]         shrunk_sat;
  logic [STEP_W-1:0]         shrunk;
  logic [STEP_W-1:0]         move;
  logic signed [VALUE_W:0]   w_ext;
  logic signed [VALUE_W:0]   w_moved;
  logic signed [VALUE_W-1:0] w_sat;
  entry_t                    wr_data;
  logic                      flipped;

  assign prod_sh = prod[PROD_W-1:FRAC_W];
  assign grown = (prod_sh > SH_W'(step_max)) ? step_max : prod_sh[STEP_W-1:0];
  assign shrunk_sat = (prod_sh > SH_W'(STEP_SAT)) ? STEP_SAT : prod_sh[STEP_W-1:0];
  assign shrunk = (shrunk_sat < step_min) ? step_min : shrunk_sat;
  assign move = (path == P_SAME) ? grown : old_step;
  assign w_ext = {old_weight[VALUE_W-1], old_weight};

  always_comb begin
    if (g_pos) begin
      w_moved = w_ext - $signed({2'b00, move});
    end else if (g_neg) begin
      w_moved = w_ext + $signed({2'b00, move});
    end else begin
      w_moved = w_ext;
    end
    if (w_moved[VALUE_W] != w_moved[VALUE_W-1]) begin
      w_sat = w_moved[VALUE_W] ? {1'b1, {(VALUE_W-1){1'b0}}}
                               : {1'b0, {(VALUE_W-1){1'b1}}};
    end else begin
      w_sat = w_moved[VALUE_W-1:0];
    end

    flipped = 1'b0;
    if (op == OP_LOAD) begin
      wr_data.weight    = val;
      wr_data.step      = step_initial;
      wr_data.last_grad = '0;
    end else begin
      case (path)
        P_SAME: begin
          wr_data.weight    = w_sat;
          wr_data.step      = grown;
          wr_data.last_grad = val;
        end
        P_FLIP: begin
          wr_data.weight    = old_weight;
          wr_data.step      = shrunk;
          wr_data.last_grad = '0;
          flipped           = 1'b1;
        end
        default: begin
          wr_data.weight    = w_sat;
          wr_data.step      = old_step;
          wr_data.last_grad = val;
        end
      endcase
    end
  end

  logic out_free;
  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == S_IDLE);

  // memory
  always_ff @(posedge clk) begin
    if (state == S_ADDR) begin
      rd_data <= mem[IDX_W'(idx_next)];
    end
    if (state == S_WRITE && out_free) begin
      mem[IDX_W'(idx)] <= wr_data;
    end
  end

  // sequencer, datapath and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (state == S_WRITE && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            op        <= operation;
            raw_index <= entry_index;
            val       <= value;
            state     <= S_ADDR;
          end
        end
        S_ADDR: begin
          idx   <= idx_next;
          state <= S_READ;
        end
        S_READ: begin
          old_weight <= rd_data.weight;
          old_step   <= rd_data.step;
          if (same_sign) begin
            path <= P_SAME;
            prod <= PROD_W'(rd_data.step) * PROD_W'(grow_factor);
          end else if (flip_sign) begin
            path <= P_FLIP;
            prod <= PROD_W'(rd_data.step) * PROD_W'(shrink_factor);
          end else begin
            path <= P_PLAIN;
            prod <= '0;
          end
          state <= S_WRITE;
        end
        S_WRITE: begin
          if (out_free) begin
            entry_index_res <= idx;
            new_weight      <= wr_data.weight;
            new_step        <= wr_data.step;
            sign_flipped    <= flipped;
            state           <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
